FILE: hdl/atb_pkg.sv
// ----------------------------------------------------------------------------
// atb_pkg
// Shared widths, codes and types for the alias table builder.
// ----------------------------------------------------------------------------
package atb_pkg;

   // Table size and fixed-point formats.
   localparam int MAX_ENTRIES    = 1024;
   localparam int IDX_W          = 10;
   localparam int CNT_W          = 11;
   localparam int PROB_FRAC_BITS = 16;
   localparam int PDF_FRAC_BITS  = 24;
   localparam int WEIGHT_W       = 32;
   localparam int WGT_W          = 31;
   localparam int SUM_W          = 41;
   localparam int PROB_W         = 27;
   localparam int THR_W          = 17;
   localparam int PDF_W          = 25;
   localparam int STATUS_W       = 2;
   localparam int FRAC_SEL_W     = 5;

   localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_FRAC_BITS;
   localparam logic [THR_W-1:0]  THR_ONE  = THR_W'(1) << PROB_FRAC_BITS;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_ENTRY = 2'd0,
      ST_BUILT = 2'd1,
      ST_NEG   = 2'd2,
      ST_BAD   = 2'd3
   } status_type;

   // Command kinds decided by the front end.
   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_LAST = 2'd1,
      CMD_NEG  = 2'd2,
      CMD_READ = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [WGT_W-1:0] weight;
      logic [IDX_W-1:0] index;
   } cmd_type;

   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] entry_index;
      logic [THR_W-1:0] threshold;
      logic [IDX_W-1:0] alias_index;
      logic [PDF_W-1:0] pdf;
      logic [CNT_W-1:0] entry_count;
   } rsp_type;

   // One LIFO entry: table index and its working probability.
   typedef struct packed {
      logic [IDX_W-1:0]  index;
      logic [PROB_W-1:0] prob;
   } stack_entry_type;

endpackage

FILE: hdl/atb_if.sv
// ----------------------------------------------------------------------------
// atb_req_if / atb_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface atb_req_if;
   import atb_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic signed [WEIGHT_W-1:0] weight;
   logic                       last_weight;
   logic [IDX_W-1:0]           read_index;

   modport source (output valid, operation, weight, last_weight, read_index, input ready);
   modport sink   (input valid, operation, weight, last_weight, read_index, output ready);
endinterface

interface atb_rsp_if;
   import atb_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    entry_index;
   logic [THR_W-1:0]    threshold;
   logic [IDX_W-1:0]    alias_index;
   logic [PDF_W-1:0]    pdf;
   logic [CNT_W-1:0]    entry_count;

   modport source (output valid, status, entry_index, threshold, alias_index, pdf,
                   entry_count, input ready);
   modport sink   (input valid, status, entry_index, threshold, alias_index, pdf,
                   entry_count, output ready);
endinterface

FILE: hdl/atb_front.sv
// ----------------------------------------------------------------------------
// atb_front
// Accepts request items, classifies them and queues commands for the back end.
// ----------------------------------------------------------------------------
module atb_front (
   input  logic             clock,
   input  logic             reset,
   atb_req_if.sink          req_bus,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output atb_pkg::cmd_type cmd
);
   import atb_pkg::*;

   cmd_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       push, pop;
   cmd_type    cmd_new;

   // Classify the incoming item.
   always_comb begin
      cmd_new.weight = req_bus.weight[WGT_W-1:0];
      cmd_new.index  = req_bus.read_index;
      if (req_bus.operation) begin
         cmd_new.kind = CMD_READ;
      end else if (req_bus.weight[WEIGHT_W-1]) begin
         cmd_new.kind = CMD_NEG;
      end else if (req_bus.last_weight) begin
         cmd_new.kind = CMD_LAST;
      end else begin
         cmd_new.kind = CMD_LOAD;
      end
   end

   // Two-entry queue toward the back end.
   assign req_bus.ready = (cnt_ff != 2'd2);
   assign push          = req_bus.valid && req_bus.ready;
   assign cmd_valid     = (cnt_ff != 2'd0);
   assign pop           = cmd_valid && cmd_ready;
   assign cmd           = q_ff[rd_ptr_ff];

   always_comb begin
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

FILE: hdl/atb_div.sv
// ----------------------------------------------------------------------------
// atb_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^frac / den).
// ----------------------------------------------------------------------------
module atb_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [atb_pkg::SUM_W-1:0]         num,
   input  logic [atb_pkg::SUM_W-1:0]         den,
   input  logic [atb_pkg::FRAC_SEL_W-1:0]    frac,
   output logic                              done,
   output logic [atb_pkg::PROB_W-1:0]        quot
);
   import atb_pkg::*;

   localparam int STEP_W = 7;

   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SUM_W-1:0]  num_ff, num_in;
   logic [SUM_W-1:0]  den_ff, den_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [PROB_W-1:0] quot_ff, quot_in;
   logic [SUM_W:0]    trial;
   logic              fits;

   // One trial subtraction per cycle; numerator bits then zeros shift in.
   always_comb begin
      trial   = {rem_ff, num_ff[SUM_W-1]};
      fits    = (trial >= {1'b0, den_ff});
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         step_in = STEP_W'(SUM_W) + STEP_W'(frac);
         busy_in = 1'b1;
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? SUM_W'(trial - {1'b0, den_ff}) : SUM_W'(trial);
         num_in  = {num_ff[SUM_W-2:0], 1'b0};
         quot_in = {quot_ff[PROB_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

FILE: hdl/atb_back.sv
// ----------------------------------------------------------------------------
// atb_back
// Executes queued commands: weight loads, negative-weight resets, table build and entry reads.
// ----------------------------------------------------------------------------
module atb_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  atb_pkg::cmd_type cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output atb_pkg::rsp_type out
);
   import atb_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_RD    = 13'b0000000000010,
      S_EMIT  = 13'b0000000000100,
      S_B_RDW = 13'b0000000001000,
      S_B_MUL = 13'b0000000010000,
      S_B_PDF = 13'b0000000100000,
      S_B_PRB = 13'b0000001000000,
      S_B_PSH = 13'b0000010000000,
      S_P_POP = 13'b0000100000000,
      S_P_PR  = 13'b0001000000000,
      S_D_RD  = 13'b0010000000000,
      S_D_WR  = 13'b0100000000000,
      S_SPARE = 13'b1000000000000
   } state_type;

   // Memories.
   logic [WGT_W-1:0] weight_mem [MAX_ENTRIES];
   logic [THR_W-1:0] thr_mem    [MAX_ENTRIES];
   logic [IDX_W-1:0] alias_mem  [MAX_ENTRIES];
   logic [PDF_W-1:0] pdf_mem    [MAX_ENTRIES];
   stack_entry_type  small_mem  [MAX_ENTRIES];
   stack_entry_type  large_mem  [MAX_ENTRIES];

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             valid_ff, valid_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] ns_ff, ns_in;
   logic [CNT_W-1:0] nl_ff, nl_in;
   logic [SUM_W-1:0] wn_ff, wn_in;
   logic [PDF_W-1:0] pdf_ff, pdf_in;
   logic [PROB_W-1:0] prob_ff, prob_in;
   logic             drain_large_ff, drain_large_in;
   rsp_type          res_ff, res_in;
   rsp_type          out_ff, out_in;
   logic             out_valid_ff, out_valid_in;

   logic [WGT_W-1:0] w_rd_ff;
   logic [THR_W-1:0] thr_rd_ff;
   logic [IDX_W-1:0] alias_rd_ff;
   logic [PDF_W-1:0] pdf_rd_ff;
   stack_entry_type  small_rd_ff, large_rd_ff;

   logic             weight_we, pdf_we, tab_we, small_we, large_we;
   logic [IDX_W-1:0] weight_wa, pdf_wa, tab_wa, small_wa, large_wa;
   logic [THR_W-1:0] thr_wd;
   logic [IDX_W-1:0] alias_wd;
   stack_entry_type  push_wd;

   logic [CNT_W-1:0] base_cnt;
   logic [SUM_W-1:0] base_sum;
   logic [PROB_W-1:0] merged_prob;
   logic             slot_free;

   logic              div_start, div_done;
   logic [SUM_W-1:0]  div_num;
   logic [FRAC_SEL_W-1:0] div_frac;
   logic [PROB_W-1:0] div_quot;

   atb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (sum_ff),
      .frac  (div_frac),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign slot_free   = !out_valid_ff || out_ready;
   assign base_cnt    = valid_ff ? '0 : cnt_ff;
   assign base_sum    = valid_ff ? '0 : sum_ff;
   assign merged_prob = large_rd_ff.prob + small_rd_ff.prob - PROB_ONE;

   // Sequencer for loads, negative weights, the build passes and reads.
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      sum_in         = sum_ff;
      valid_in       = valid_ff;
      i_in           = i_ff;
      ns_in          = ns_ff;
      nl_in          = nl_ff;
      wn_in          = wn_ff;
      pdf_in         = pdf_ff;
      prob_in        = prob_ff;
      drain_large_in = drain_large_ff;
      res_in         = res_ff;
      out_valid_in   = out_valid_ff && !out_ready;
      out_in         = out_ff;
      cmd_ready      = 1'b0;
      div_start      = 1'b0;
      div_num        = '0;
      div_frac       = '0;
      weight_we      = 1'b0;
      weight_wa      = base_cnt[IDX_W-1:0];
      pdf_we         = 1'b0;
      pdf_wa         = i_ff[IDX_W-1:0];
      tab_we         = 1'b0;
      tab_wa         = small_rd_ff.index;
      thr_wd         = small_rd_ff.prob[THR_W-1:0];
      alias_wd       = large_rd_ff.index;
      small_we       = 1'b0;
      small_wa       = ns_ff[IDX_W-1:0];
      large_we       = 1'b0;
      large_wa       = nl_ff[IDX_W-1:0];
      push_wd.index  = i_ff[IDX_W-1:0];
      push_wd.prob   = prob_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_ready = 1'b1;
               res_in    = '0;
               unique case (cmd.kind) inside
                  CMD_READ: begin
                     res_in.entry_index = cmd.index;
                     if (!valid_ff) begin
                        res_in.status = ST_BAD;
                        state_in      = S_EMIT;
                     end else begin
                        res_in.entry_count = cnt_ff;
                        if ({1'b0, cmd.index} >= cnt_ff) begin
                           res_in.status = ST_BAD;
                           state_in      = S_EMIT;
                        end else begin
                           res_in.status = ST_ENTRY;
                           state_in      = S_RD;
                        end
                     end
                  end
                  CMD_NEG: begin
                     valid_in      = 1'b0;
                     cnt_in        = '0;
                     sum_in        = '0;
                     res_in.status = ST_NEG;
                     state_in      = S_EMIT;
                  end
                  CMD_LOAD, CMD_LAST: begin
                     valid_in = 1'b0;
                     cnt_in   = base_cnt;
                     sum_in   = base_sum;
                     if (base_cnt < CNT_W'(MAX_ENTRIES)) begin
                        weight_we = 1'b1;
                        cnt_in    = base_cnt + CNT_W'(1);
                        sum_in    = base_sum + SUM_W'(cmd.weight);
                     end
                     if (cmd.kind == CMD_LAST) begin
                        i_in     = '0;
                        ns_in    = '0;
                        nl_in    = '0;
                        state_in = S_B_RDW;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         S_RD: begin
            res_in.threshold   = thr_rd_ff;
            res_in.alias_index = alias_rd_ff;
            res_in.pdf         = pdf_rd_ff;
            state_in           = S_EMIT;
         end

         S_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_in       = res_ff;
               state_in     = S_IDLE;
            end
         end

         // First pass: scale each weight and sort it onto a LIFO.
         S_B_RDW: state_in = S_B_MUL;

         S_B_MUL: begin
            wn_in = SUM_W'(w_rd_ff) * SUM_W'(cnt_ff);
            if (sum_ff == '0) begin
               pdf_in   = '0;
               prob_in  = '0;
               state_in = S_B_PSH;
            end else begin
               div_start = 1'b1;
               div_num   = SUM_W'(w_rd_ff);
               div_frac  = FRAC_SEL_W'(PDF_FRAC_BITS);
               state_in  = S_B_PDF;
            end
         end

         S_B_PDF: begin
            if (div_done) begin
               pdf_in    = div_quot[PDF_W-1:0];
               div_start = 1'b1;
               div_num   = wn_ff;
               div_frac  = FRAC_SEL_W'(PROB_FRAC_BITS);
               state_in  = S_B_PRB;
            end
         end

         S_B_PRB: begin
            if (div_done) begin
               prob_in  = div_quot;
               state_in = S_B_PSH;
            end
         end

         S_B_PSH: begin
            pdf_we = 1'b1;
            if (prob_ff < PROB_ONE) begin
               small_we = 1'b1;
               ns_in    = ns_ff + CNT_W'(1);
            end else begin
               large_we = 1'b1;
               nl_in    = nl_ff + CNT_W'(1);
            end
            i_in     = i_ff + CNT_W'(1);
            state_in = (i_ff + CNT_W'(1) == cnt_ff) ? S_P_POP : S_B_RDW;
         end

         // Second pass: pair a small entry with a large one.
         S_P_POP: begin
            if (ns_ff != '0 && nl_ff != '0) begin
               ns_in    = ns_ff - CNT_W'(1);
               nl_in    = nl_ff - CNT_W'(1);
               state_in = S_P_PR;
            end else begin
               state_in = S_D_RD;
            end
         end

         S_P_PR: begin
            tab_we        = 1'b1;
            push_wd.index = large_rd_ff.index;
            push_wd.prob  = merged_prob;
            if (merged_prob < PROB_ONE) begin
               small_we = 1'b1;
               ns_in    = ns_ff + CNT_W'(1);
            end else begin
               large_we = 1'b1;
               nl_in    = nl_ff + CNT_W'(1);
            end
            state_in = S_P_POP;
         end

         // Leftovers keep the full threshold and alias themselves.
         S_D_RD: begin
            if (nl_ff != '0) begin
               nl_in          = nl_ff - CNT_W'(1);
               drain_large_in = 1'b1;
               state_in       = S_D_WR;
            end else if (ns_ff != '0) begin
               ns_in          = ns_ff - CNT_W'(1);
               drain_large_in = 1'b0;
               state_in       = S_D_WR;
            end else begin
               valid_in           = 1'b1;
               res_in             = '0;
               res_in.status      = ST_BUILT;
               res_in.entry_count = cnt_ff;
               state_in           = S_EMIT;
            end
         end

         S_D_WR: begin
            tab_we   = 1'b1;
            tab_wa   = drain_large_ff ? large_rd_ff.index : small_rd_ff.index;
            thr_wd   = THR_ONE;
            alias_wd = tab_wa;
            state_in = S_D_RD;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         valid_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
         i_ff         <= '0;
         ns_ff        <= '0;
         nl_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
         i_ff         <= i_in;
         ns_ff        <= ns_in;
         nl_ff        <= nl_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      wn_ff          <= wn_in;
      pdf_ff         <= pdf_in;
      prob_ff        <= prob_in;
      drain_large_ff <= drain_large_in;
      res_ff         <= res_in;
      out_ff         <= out_in;
   end

   // Memory writes and registered reads.
   always_ff @(posedge clock) begin
      if (weight_we) begin
         weight_mem[weight_wa] <= cmd.weight;
      end
      if (pdf_we) begin
         pdf_mem[pdf_wa] <= pdf_ff;
      end
      if (tab_we) begin
         thr_mem[tab_wa]   <= thr_wd;
         alias_mem[tab_wa] <= alias_wd;
      end
      if (small_we) begin
         small_mem[small_wa] <= push_wd;
      end
      if (large_we) begin
         large_mem[large_wa] <= push_wd;
      end
      w_rd_ff     <= weight_mem[i_ff[IDX_W-1:0]];
      thr_rd_ff   <= thr_mem[cmd.index];
      alias_rd_ff <= alias_mem[cmd.index];
      pdf_rd_ff   <= pdf_mem[cmd.index];
      small_rd_ff <= small_mem[IDX_W'(ns_ff - CNT_W'(1))];
      large_rd_ff <= large_mem[IDX_W'(nl_ff - CNT_W'(1))];
   end

   assign out_valid = out_valid_ff;
   assign out       = out_ff;

endmodule

FILE: hdl/alias_table_builder_core.sv
// ----------------------------------------------------------------------------
// alias_table_builder_core
// Loads weights, builds an alias sampling table and answers entry reads.
// ----------------------------------------------------------------------------
// Loads: an accepted load waits in a two-entry queue until the back end is idle, so loads stream
// at one per cycle while it is idle; a read result passes S_RD and S_EMIT to the output register
// (a rejected read skips S_RD), and the queue takes items meanwhile.
// Build: per entry S_B_RDW, S_B_MUL, two one-bit-per-cycle divisions of 65 and 57 steps (pdf,
// then probability; none for a zero sum), S_B_PSH; pairs use S_P_POP/S_P_PR, leftovers S_D_RD/S_D_WR.
// Reset: synchronous, clears counts, sum and table valid; memories are not cleared.
module alias_table_builder_core (
   input  logic      clock,
   input  logic      reset,
   atb_req_if.sink   req_bus,
   atb_rsp_if.source rsp_bus
);
   import atb_pkg::*;

   logic    cmd_valid, cmd_ready;
   cmd_type cmd;
   rsp_type out;

   atb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   atb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out       (out)
   );

   // Result fields onto the channel.
   assign rsp_bus.status      = out.status;
   assign rsp_bus.entry_index = out.entry_index;
   assign rsp_bus.threshold   = out.threshold;
   assign rsp_bus.alias_index = out.alias_index;
   assign rsp_bus.pdf         = out.pdf;
   assign rsp_bus.entry_count = out.entry_count;

endmodule

FILE: hdl/atb_checker.sv
// ----------------------------------------------------------------------------
// atb_checker
// Port-level checks on the result channel of the alias table builder.
// ----------------------------------------------------------------------------
module atb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [atb_pkg::STATUS_W-1:0]  rsp_status,
   input logic [atb_pkg::IDX_W-1:0]     rsp_entry_index,
   input logic [atb_pkg::THR_W-1:0]     rsp_threshold,
   input logic [atb_pkg::IDX_W-1:0]     rsp_alias_index,
   input logic [atb_pkg::PDF_W-1:0]     rsp_pdf,
   input logic [atb_pkg::CNT_W-1:0]     rsp_entry_count
);
   import atb_pkg::*;

   // A pending result stays until it is taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped before it was taken");

   // A returned entry lies inside the built table.
   a_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ENTRY |->
         {1'b0, rsp_entry_index} < rsp_entry_count && rsp_alias_index < rsp_entry_count)
      else $error("entry or alias index outside the table");

   // Thresholds and pdfs never exceed one.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ENTRY |->
         rsp_threshold <= THR_ONE && rsp_pdf <= (PDF_W'(1) << PDF_FRAC_BITS))
      else $error("threshold or pdf above one");

   // Only entry reads carry table data.
   a_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_ENTRY |->
         rsp_threshold == '0 && rsp_alias_index == '0 && rsp_pdf == '0)
      else $error("table data on a non-read result");

   // A finished build always holds at least one entry.
   a_built: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_BUILT |-> rsp_entry_count != '0)
      else $error("build done with an empty table");

endmodule

bind alias_table_builder_core atb_checker u_atb_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_entry_index (rsp_bus.entry_index),
   .rsp_threshold   (rsp_bus.threshold),
   .rsp_alias_index (rsp_bus.alias_index),
   .rsp_pdf         (rsp_bus.pdf),
   .rsp_entry_count (rsp_bus.entry_count)
);
